/* design/nspl_pkg.sv */
package nspl_pkg;

    localparam int MAX_SEEDS       = 1024;
    localparam int GRID_COORD_BITS = 12;
    localparam int FRAC_BITS       = 8;

    // widths of the port fields
    localparam int FUNC_W    = 1;
    localparam int SIDX_W    = 10;
    localparam int SCOORD_W  = 20;
    localparam int PIX_W     = 12;
    localparam int REGION_W  = 10;
    localparam int CNT_W     = 11;

    // internal widths
    localparam int IDX_W     = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int COORD_W   = GRID_COORD_BITS + FRAC_BITS;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = SQ_W + 1;
    localparam int CLAMP_W   = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;
    localparam int LDCMP_W   = (SIDX_W > IDX_W + 1) ? SIDX_W : IDX_W + 1;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_LABEL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_seed;

    // travels with each seed through the distance pipeline
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

/* design/nspl_if.sv */
interface nspl_req_if import nspl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [SIDX_W-1:0]   seed_index;
    logic [SCOORD_W-1:0] seed_x;
    logic [SCOORD_W-1:0] seed_y;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;

    modport source (output valid, func, seed_index, seed_x, seed_y, pixel_x, pixel_y,
                    input ready);
    modport sink   (input valid, func, seed_index, seed_x, seed_y, pixel_x, pixel_y,
                    output ready);
endinterface

interface nspl_rsp_if import nspl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [REGION_W-1:0] region_id;

    modport source (output valid, region_id, input ready);
    modport sink   (input valid, region_id, output ready);
endinterface

/* design/nearest_seed_pixel_labeler.sv */
// channel    dir  beat fields                                          notes
// i_req      in   func seed_index seed_x seed_y pixel_x pixel_y        load or label
// o_rsp      out  region_id                                            one per label
// i_cfg_*    in   seed_count (11 bits)                                 write only
//
// A load gives no result. A label holds input off from accept until its result is
// loaded into the output register: one seed RAM read per cycle feeds a three-stage
// distance pipe and the running-best compare.
// Reset clears control and sets seed_count to 1; the seed table is not cleared.
// A waiting result sits in the output register while the next beat is accepted; a
// finished search holds until that register is free.
module nearest_seed_pixel_labeler import nspl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    nspl_req_if.sink         i_req,
    nspl_rsp_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_seed_count;
    logic [IDX_W-1:0]           r_addr, n_addr;
    logic [IDX_W-1:0]           r_last, n_last;
    logic [GRID_COORD_BITS-1:0] r_px, r_py;
    t_tag                       r_rd_tag;
    t_tag                       cmp_tag;
    logic                       cmp_match;
    logic [DIST_W-1:0]          cmp_dist;
    t_seed                      rd_seed;
    t_seed                      wr_seed;
    logic [DIST_W-1:0]          r_best_dist;
    logic [IDX_W-1:0]           r_best_id;
    logic                       r_on_hit;
    logic [IDX_W-1:0]           r_on_id;
    logic                       r_out_valid;
    logic [REGION_W-1:0]        r_out_id;
    logic [CLAMP_W-1:0]         cnt_ext, cnt_clamp;
    logic                       req_fire, label_fire, load_we, rd_en, out_free, out_load;

    assign req_fire   = i_req.valid && i_req.ready;
    assign label_fire = req_fire && (i_req.func == FUNC_LABEL);
    assign load_we    = req_fire && (i_req.func == FUNC_LOAD) &&
                        (LDCMP_W'(i_req.seed_index) < LDCMP_W'(MAX_SEEDS));
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign wr_seed.x  = COORD_W'(i_req.seed_x);
    assign wr_seed.y  = COORD_W'(i_req.seed_y);

    // zero searches entry 0, large counts saturate
    always_comb begin
        cnt_ext = CLAMP_W'(r_seed_count);
        priority if (cnt_ext == '0) begin
            cnt_clamp = CLAMP_W'(1);
        end else if (cnt_ext > CLAMP_W'(MAX_SEEDS)) begin
            cnt_clamp = CLAMP_W'(MAX_SEEDS);
        end else begin
            cnt_clamp = cnt_ext;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_last      = r_last;
        rd_en       = 1'b0;
        out_load    = 1'b0;
        i_req.ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (label_fire) begin
                    n_state = ST_SCAN;
                    n_addr  = '0;
                    n_last  = IDX_W'(cnt_clamp - CLAMP_W'(1));
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (r_addr == r_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (cmp_tag.valid && cmp_tag.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_seed_count   <= CNT_W'(1);
            r_rd_tag.valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_rd_tag.valid <= rd_en;
            if (i_cfg_we) begin
                r_seed_count <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr         <= n_addr;
        r_last         <= n_last;
        r_rd_tag.first <= (r_addr == '0);
        r_rd_tag.last  <= (r_addr == r_last);
        r_rd_tag.idx   <= r_addr;
        if (label_fire) begin
            r_px <= GRID_COORD_BITS'(i_req.pixel_x);
            r_py <= GRID_COORD_BITS'(i_req.pixel_y);
        end
        // running best: lowest index wins ties, highest index wins on-pixel
        if (cmp_tag.valid) begin
            if (cmp_tag.first || cmp_dist < r_best_dist) begin
                r_best_dist <= cmp_dist;
                r_best_id   <= cmp_tag.idx;
            end
            if (cmp_tag.first || cmp_match) begin
                r_on_hit <= cmp_match;
                r_on_id  <= cmp_tag.idx;
            end
        end
        if (out_load) begin
            r_out_id <= r_on_hit ? REGION_W'(r_on_id) : REGION_W'(r_best_id);
        end
    end

    nspl_seed_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (IDX_W'(i_req.seed_index)),
        .i_wdata (wr_seed),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_seed)
    );

    nspl_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_seed  (rd_seed),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_tag   (cmp_tag),
        .o_match (cmp_match),
        .o_dist  (cmp_dist)
    );

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.region_id = r_out_id;

    a_label_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        label_fire |=> (r_state == ST_SCAN) && (r_addr == '0))
        else $error("label beat did not start a scan at entry 0");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_addr <= r_last))
        else $error("scan address ran past last seed");

    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmp_tag.valid && cmp_tag.last) |-> (r_state == ST_DRAIN))
        else $error("last seed reached compare outside drain");

endmodule

/* design/nspl_seed_ram.sv */
module nspl_seed_ram import nspl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_seed            i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_seed            o_rdata
);

    t_seed r_mem [MAX_SEEDS];
    t_seed r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/nspl_dist.sv */
module nspl_dist import nspl_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tag                       i_tag,
    input  t_seed                      i_seed,
    input  logic [GRID_COORD_BITS-1:0] i_px,
    input  logic [GRID_COORD_BITS-1:0] i_py,
    output t_tag                       o_tag,
    output logic                       o_match,
    output logic [DIST_W-1:0]          o_dist
);

    logic [COORD_W-1:0] pxf;
    logic [COORD_W-1:0] pyf;

    // stage A: differences and on-pixel check
    t_tag               r_tag_a;
    logic [COORD_W-1:0] r_dx;
    logic [COORD_W-1:0] r_dy;
    logic               r_match_a;
    // stage M: squares
    t_tag               r_tag_m;
    logic [SQ_W-1:0]    r_qx;
    logic [SQ_W-1:0]    r_qy;
    logic               r_match_m;
    // stage S: sum, carry kept
    t_tag               r_tag_s;
    logic [DIST_W-1:0]  r_dist;
    logic               r_match_s;

    assign pxf = COORD_W'(i_px) << FRAC_BITS;
    assign pyf = COORD_W'(i_py) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a.valid <= 1'b0;
            r_tag_m.valid <= 1'b0;
            r_tag_s.valid <= 1'b0;
        end else begin
            r_tag_a.valid <= i_tag.valid;
            r_tag_m.valid <= r_tag_a.valid;
            r_tag_s.valid <= r_tag_m.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag_a.first <= i_tag.first;
        r_tag_a.last  <= i_tag.last;
        r_tag_a.idx   <= i_tag.idx;
        r_dx          <= (pxf >= i_seed.x) ? pxf - i_seed.x : i_seed.x - pxf;
        r_dy          <= (pyf >= i_seed.y) ? pyf - i_seed.y : i_seed.y - pyf;
        r_match_a     <= (i_seed.x[COORD_W-1:FRAC_BITS] == i_px) &&
                         (i_seed.y[COORD_W-1:FRAC_BITS] == i_py);

        r_tag_m.first <= r_tag_a.first;
        r_tag_m.last  <= r_tag_a.last;
        r_tag_m.idx   <= r_tag_a.idx;
        r_qx          <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_qy          <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_match_m     <= r_match_a;

        r_tag_s.first <= r_tag_m.first;
        r_tag_s.last  <= r_tag_m.last;
        r_tag_s.idx   <= r_tag_m.idx;
        r_dist        <= DIST_W'(r_qx) + DIST_W'(r_qy);
        r_match_s     <= r_match_m;
    end

    assign o_tag   = r_tag_s;
    assign o_match = r_match_s;
    assign o_dist  = r_dist;

endmodule
